// ===== rtl/drs_pkg.sv =====
package drs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int ID_W     = 16;
   localparam int STAMP_W  = 32;
   localparam int CYL_W    = 16;
   localparam int ADDR_W   = 32;
   localparam int PROC_W   = 16;
   localparam int POLICY_W = 2;

   localparam logic OP_ARRIVE   = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
   localparam logic [POLICY_W-1:0] POL_SSTF = 2'd1;
   localparam logic [POLICY_W-1:0] POL_LOOK = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [STAMP_W-1:0] stamp;
      logic [CYL_W-1:0]   cyl;
      logic [ADDR_W-1:0]  addr;
      logic [PROC_W-1:0]  proc_id;
   } entry_type;

   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   idx;
      logic [CYL_W-1:0]   span;
      logic [STAMP_W-1:0] stamp;
   } cand_type;

endpackage

// ===== rtl/drs_req_if.sv =====
interface drs_req_if import drs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [ID_W-1:0]     ident;
   logic [STAMP_W-1:0]  arrival_time;
   logic [CYL_W-1:0]    cylinder;
   logic [ADDR_W-1:0]   disk_address;
   logic [PROC_W-1:0]   owner_process;
   logic [CYL_W-1:0]    head_cylinder;
   logic                scan_up;

   modport source (output valid, operation, ident, arrival_time, cylinder,
                   disk_address, owner_process, head_cylinder, scan_up,
                   input ready);
   modport sink (input valid, operation, ident, arrival_time, cylinder,
                 disk_address, owner_process, head_cylinder, scan_up,
                 output ready);
endinterface

interface drs_rsp_if import drs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                busy_res;
   logic [ID_W-1:0]     served_id;
   logic [STAMP_W-1:0]  served_time;
   logic [CYL_W-1:0]    served_cylinder;
   logic [ADDR_W-1:0]   served_address;
   logic [PROC_W-1:0]   served_process;
   logic                dropped;

   modport source (output valid, busy_res, served_id, served_time, served_cylinder,
                   served_address, served_process, dropped,
                   input ready);
   modport sink (input valid, busy_res, served_id, served_time, served_cylinder,
                 served_address, served_process, dropped,
                 output ready);
endinterface

interface drs_csr_if import drs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [POLICY_W-1:0] policy;

   modport source (output valid, policy, input ready);
   modport sink (input valid, policy, output ready);
endinterface

// ===== rtl/disk_request_scheduler_core.sv =====
// Disk request scheduler: one request in service plus a queue of QUEUE_DEPTH
// waiting requests held in arrival order in a synchronous memory with one read
// and one write port. Every accepted request yields exactly one result item. An
// arrival, or a completion with an empty queue, goes from idle straight to the
// output stage. A completion with a nonempty queue reads every queued entry once
// to choose the next request, picks it, then rereads the chosen entry and moves
// each later entry down one place, loads the output register and returns to
// idle; the memory read port delivers one entry per cycle. Items are taken one
// at a time; a new item is accepted while the previous result still waits on
// the output register.
module disk_request_scheduler_core import drs_pkg::*; (
   input  logic clock,
   input  logic reset,
   drs_req_if.sink   req_chan,
   drs_rsp_if.source rsp_chan,
   drs_csr_if.sink   csr_chan
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_PICK  = 5'b00100,
      ST_SHIFT = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   function automatic cand_type cand_update(cand_type cur, cand_type nw, logic ok);
      logic wins;
      wins = !cur.found || (nw.span < cur.span) ||
             ((nw.span == cur.span) && (nw.stamp < cur.stamp));
      return (ok && wins) ? nw : cur;
   endfunction

   state_type           state_ff, state_in;
   logic [POLICY_W-1:0] policy_ff, policy_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                busy_ff, busy_in;
   entry_type           srv_ff, srv_in;
   logic                drop_ff, drop_in;
   logic [CYL_W-1:0]    head_ff, head_in;
   logic                up_ff, up_in;
   logic [CNT_W-1:0]    iss_ff, iss_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]    pick_ff, pick_in;
   cand_type            first_ff, first_in;
   cand_type            same_ff, same_in;
   cand_type            dir_ff, dir_in;
   cand_type            near_ff, near_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_busy_ff, out_busy_in;
   entry_type           out_entry_ff, out_entry_in;
   logic                out_drop_ff, out_drop_in;

   entry_type           queue_mem [QUEUE_DEPTH];
   entry_type           rd_data_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [IDX_W-1:0]    mem_raddr;
   entry_type           mem_wdata;

   logic                req_fire;
   entry_type           req_entry;
   logic [CYL_W-1:0]    rd_dist;
   cand_type            nw_time;
   cand_type            nw_dist;
   logic                dir_ok;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign req_entry.id      = req_chan.ident;
   assign req_entry.stamp   = req_chan.arrival_time;
   assign req_entry.cyl     = req_chan.cylinder;
   assign req_entry.addr    = req_chan.disk_address;
   assign req_entry.proc_id = req_chan.owner_process;

   assign rd_dist = (rd_data_ff.cyl >= head_ff) ? rd_data_ff.cyl - head_ff
                                                : head_ff - rd_data_ff.cyl;
   assign dir_ok  = up_ff ? (rd_data_ff.cyl > head_ff) : (rd_data_ff.cyl < head_ff);

   always_comb begin
      nw_time.found = 1'b1;
      nw_time.idx   = pend_idx_ff;
      nw_time.span  = '0;
      nw_time.stamp = rd_data_ff.stamp;
      nw_dist       = nw_time;
      nw_dist.span  = rd_dist;
   end

   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      count_in     = count_ff;
      busy_in      = busy_ff;
      srv_in       = srv_ff;
      drop_in      = drop_ff;
      head_in      = head_ff;
      up_in        = up_ff;
      iss_in       = iss_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      pick_in      = pick_ff;
      first_in     = first_ff;
      same_in      = same_ff;
      dir_in       = dir_ff;
      near_in      = near_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_busy_in  = out_busy_ff;
      out_entry_in = out_entry_ff;
      out_drop_in  = out_drop_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IDX_W-1:0];
      mem_wdata    = req_entry;
      mem_raddr    = '0;

      if (csr_chan.valid) begin
         policy_in = csr_chan.policy;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               drop_in  = 1'b0;
               head_in  = req_chan.head_cylinder;
               up_in    = req_chan.scan_up;
               iss_in   = '0;
               first_in = '0;
               same_in  = '0;
               dir_in   = '0;
               near_in  = '0;
               state_in = ST_DONE;
               if (req_chan.operation == OP_ARRIVE) begin
                  if (!busy_ff) begin
                     busy_in = 1'b1;
                     srv_in  = req_entry;
                  end else if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     drop_in = 1'b1;
                  end
               end else if (count_ff == '0) begin
                  busy_in = 1'b0;
                  srv_in  = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               first_in = cand_update(first_ff, nw_time, 1'b1);
               same_in  = cand_update(same_ff, nw_time, rd_data_ff.cyl == head_ff);
               dir_in   = cand_update(dir_ff, nw_dist, dir_ok);
               near_in  = cand_update(near_ff, nw_dist, 1'b1);
            end
            if (iss_ff < count_ff) begin
               mem_raddr   = iss_ff[IDX_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = iss_ff[IDX_W-1:0];
               iss_in      = iss_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            case (policy_ff)
               POL_SSTF: pick_in = near_ff.idx;
               POL_LOOK: begin
                  if (same_ff.found) begin
                     pick_in = same_ff.idx;
                  end else if (dir_ff.found) begin
                     pick_in = dir_ff.idx;
                  end else begin
                     pick_in = near_ff.idx;
                  end
               end
               default: pick_in = first_ff.idx;
            endcase
            iss_in   = CNT_W'(pick_in);
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            // chosen entry goes into service, later entries move down one place
            if (pend_ff) begin
               if (pend_idx_ff == pick_ff) begin
                  busy_in = 1'b1;
                  srv_in  = rd_data_ff;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = pend_idx_ff - IDX_W'(1);
                  mem_wdata = rd_data_ff;
               end
            end
            if (iss_ff < count_ff) begin
               mem_raddr   = iss_ff[IDX_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = iss_ff[IDX_W-1:0];
               iss_in      = iss_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_busy_in  = busy_ff;
               out_entry_in = srv_ff;
               out_drop_in  = drop_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= queue_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POL_FCFS;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         srv_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         srv_ff       <= srv_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_ff      <= drop_in;
      head_ff      <= head_in;
      up_ff        <= up_in;
      iss_ff       <= iss_in;
      pend_idx_ff  <= pend_idx_in;
      pick_ff      <= pick_in;
      first_ff     <= first_in;
      same_ff      <= same_in;
      dir_ff       <= dir_in;
      near_ff      <= near_in;
      out_busy_ff  <= out_busy_in;
      out_entry_ff <= out_entry_in;
      out_drop_ff  <= out_drop_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.busy_res        = out_busy_ff;
   assign rsp_chan.served_id       = out_entry_ff.id;
   assign rsp_chan.served_time     = out_entry_ff.stamp;
   assign rsp_chan.served_cylinder = out_entry_ff.cyl;
   assign rsp_chan.served_address  = out_entry_ff.addr;
   assign rsp_chan.served_process  = out_entry_ff.proc_id;
   assign rsp_chan.dropped         = out_drop_ff;

endmodule
